### hdl/start_byte_packet_deframer_sum_check_macros.svh
// Assertion macros for the start-byte packet deframer.
`ifndef START_BYTE_PACKET_DEFRAMER_SUM_CHECK_MACROS_SVH
`define START_BYTE_PACKET_DEFRAMER_SUM_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge outside reset.
`define SBPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked at every rising edge, reset included.
`define SBPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBPD_ASSERT(lbl, clk, rstn, prop, msg)
`define SBPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/sbpd_pkg.sv
// Types and constants shared by the start-byte packet deframer modules.
package sbpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 6;
  localparam int TOTAL_W  = 32;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // register index sits in paddr[2] (one 32-bit register per word)
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hFF;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_CLOSE = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_EMIT,
    ST_ERROR
  } back_state_t;

  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic               last;
    logic [TOTAL_W-1:0] good_packets;
    logic [TOTAL_W-1:0] bad_packets;
  } result_t;

endpackage

### hdl/sbpd_front.sv
// Front end: accepts bytes, tracks framing state and issues store/close commands.
module sbpd_front #(
  parameter int PACKET_BYTES = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  input  logic [7:0]           start_byte,
  input  logic                 fifo_full,
  output logic                 fifo_push,
  output sbpd_pkg::cmd_t       fifo_cmd
);
  import sbpd_pkg::*;

  localparam int FW = $clog2(PACKET_BYTES + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(PACKET_BYTES);

  logic          collecting_r, collecting_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          accept;
  logic          is_start;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign is_start = (in_rx_byte == start_byte);

  always_comb begin
    collecting_nxt = collecting_r;
    fill_nxt       = fill_r;
    fifo_push      = 1'b0;
    fifo_cmd.op    = OP_STORE;
    fifo_cmd.slot  = '0;
    fifo_cmd.data  = in_rx_byte;
    if (accept) begin
      if (!collecting_r) begin
        if (is_start) begin
          fifo_push      = 1'b1;
          collecting_nxt = 1'b1;
          fill_nxt       = FW'(1);
        end
      end else if (is_start) begin
        // judge the open packet, then reopen with this byte in slot 0
        fifo_push   = 1'b1;
        fifo_cmd.op = OP_CLOSE;
        fill_nxt    = FW'(1);
      end else if (fill_r < FILL_MAX) begin
        fifo_push     = 1'b1;
        fifo_cmd.slot = SLOT_W'(fill_r);
        fill_nxt      = fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      fill_r       <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      fill_r       <= fill_nxt;
    end
  end

endmodule

### hdl/sbpd_cmd_fifo.sv
// Short command queue between the front end and the packet engine.
`include "start_byte_packet_deframer_sum_check_macros.svh"

module sbpd_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sbpd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sbpd_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import sbpd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `SBPD_ASSERT(a_fifo_no_overflow, clk, rst_n, !(push && full), "push into full queue")
  `SBPD_ASSERT(a_fifo_no_underflow, clk, rst_n, !(pop && empty), "pop from empty queue")
  `SBPD_ASSERT(a_fifo_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "queue count overrun")

endmodule

### hdl/sbpd_back.sv
// Packet engine: packet store, checksum pass, result sequencing and counters.
`include "start_byte_packet_deframer_sum_check_macros.svh"

module sbpd_back #(
  parameter int PACKET_BYTES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fifo_empty,
  input  sbpd_pkg::cmd_t    fifo_cmd,
  output logic              fifo_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output sbpd_pkg::result_t out_res
);
  import sbpd_pkg::*;

  localparam int AW = $clog2(PACKET_BYTES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(PACKET_BYTES - 1);

  // packet store with per-slot valid bits; a never-written slot reads as zero
  logic [BYTE_W-1:0]       mem [PACKET_BYTES];
  logic [PACKET_BYTES-1:0] vld_r;
  logic [BYTE_W-1:0]       rd_data_r;
  logic                    rd_vld_r;
  logic [BYTE_W-1:0]       rd_byte;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  back_state_t        state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  sum_r, sum_nxt;
  logic [BYTE_W-1:0]  open_r, open_nxt;
  logic [TOTAL_W-1:0] good_r, good_nxt;
  logic [TOTAL_W-1:0] bad_r, bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;
  logic               out_free;

  assign rd_byte   = rd_vld_r ? rd_data_r : '0;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    open_nxt      = open_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    fifo_pop      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = open_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop = 1'b1;
          if (fifo_cmd.op == OP_STORE) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(fifo_cmd.slot);
            mem_wdata = fifo_cmd.data;
          end else begin
            open_nxt  = fifo_cmd.data;
            rd_en     = 1'b1;
            cnt_nxt   = AW'(1);
            sum_nxt   = '0;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // data in rd_byte belongs to slot cnt_r-1
        sum_nxt = sum_r + rd_byte;
        rd_en   = 1'b1;
        rd_addr = cnt_r;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ST_CHECK;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_CHECK: begin
        if (sum_r == rd_byte) begin
          good_nxt  = (good_r == '1) ? good_r : good_r + TOTAL_W'(1);
          rd_en     = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          bad_nxt   = (bad_r == '1) ? bad_r : bad_r + TOTAL_W'(1);
          state_nxt = ST_ERROR;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_res_nxt.kind         = KIND_BYTE;
          out_res_nxt.byte_index   = SLOT_W'(cnt_r);
          out_res_nxt.byte_value   = rd_byte;
          out_res_nxt.last         = (cnt_r == LAST_SLOT);
          out_res_nxt.good_packets = good_r;
          out_res_nxt.bad_packets  = bad_r;
          if (cnt_r == LAST_SLOT) begin
            mem_we    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_r + AW'(1);
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_res_nxt.kind         = KIND_ERROR;
          out_res_nxt.byte_index   = '0;
          out_res_nxt.byte_value   = '0;
          out_res_nxt.last         = 1'b1;
          out_res_nxt.good_packets = good_r;
          out_res_nxt.bad_packets  = bad_r;
          mem_we                   = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    open_r    <= open_nxt;
    out_res_r <= out_res_nxt;
  end

  `SBPD_ASSERT(a_err_is_last, clk, rst_n, (out_valid_r && (out_res_r.kind == KIND_ERROR)) |-> out_res_r.last, "error result not marked last")
  `SBPD_ASSERT(a_index_range, clk, rst_n, (out_valid_r && (out_res_r.kind == KIND_BYTE)) |-> (out_res_r.byte_index <= SLOT_W'(PACKET_BYTES - 1)), "byte index past packet")
  `SBPD_ASSERT(a_good_monotonic, clk, rst_n, 1'b1 |=> (good_r >= $past(good_r)), "good count went down")

endmodule

### hdl/start_byte_packet_deframer_sum_check.sv
// Start-byte packet deframer with 8-bit additive checksum: top level.
//
// Input channel (in_valid / in_stall / in_rx_byte): one received serial byte
// per transfer. Bytes pass through a four-entry command queue, so the input
// takes one byte per cycle until the queue fills; in_stall is the queue-full
// flag. The packet engine writes a plain data byte into the store on its pop.
// Output channel (out_valid / out_stall / out_*): a start byte that closes a
// packet yields PACKET_BYTES transfers for a good packet (last set on the
// final one) or one error transfer. Judging is a pass of sequential reads
// over the single-port packet store in ST_SUM, a compare in ST_CHECK, then
// one result per cycle while out_stall is low. The close command passes the
// queue, the summing and check states and the output register before the
// first result is valid; good packets emit from ST_EMIT, errors from ST_ERROR.
// A stalled result is held in the output register; the engine waits there
// while the queue keeps taking bytes.
// Register 0 (start_byte, paddr[2] = 0) is written through the APB-style port;
// reset sets it to 0xFF. Reset clears framing state, counters and the slot
// valid bits (unwritten slots read as zero) without a clearing pass.
module start_byte_packet_deframer_sum_check #(
  parameter int PACKET_BYTES = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [5:0]                    out_byte_index,
  output logic [7:0]                    out_byte_value,
  output logic                          out_last,
  output logic [31:0]                   out_good_packets,
  output logic [31:0]                   out_bad_packets,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbpd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import sbpd_pkg::*;

  logic [BYTE_W-1:0] start_byte_r;
  logic              cfg_wr;
  logic              fifo_full, fifo_empty, fifo_push, fifo_pop;
  cmd_t              push_cmd, pop_cmd;
  result_t           res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START_BYTE);
  assign prdata = (paddr[2] == REG_START_BYTE) ?
                  {{(PDATA_W-BYTE_W){1'b0}}, start_byte_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
    end else if (cfg_wr) begin
      start_byte_r <= pwdata[BYTE_W-1:0];
    end
  end

  sbpd_front #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .start_byte (start_byte_r),
    .fifo_full  (fifo_full),
    .fifo_push  (fifo_push),
    .fifo_cmd   (push_cmd)
  );

  sbpd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  sbpd_back #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_cmd   (pop_cmd),
    .fifo_pop   (fifo_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_kind         = res.kind;
  assign out_byte_index   = res.byte_index;
  assign out_byte_value   = res.byte_value;
  assign out_last         = res.last;
  assign out_good_packets = res.good_packets;
  assign out_bad_packets  = res.bad_packets;

endmodule
